### hdl/lspq_pkg.sv
// Shared types, constants and helpers for the linear-scan priority queue.
`default_nettype none
package lspq_pkg;

	localparam int DEPTH        = 64;
	localparam int ELEMENT_BITS = 16;
	localparam int KEY_BITS     = 32;
	localparam int ADDR_BITS    = $clog2(DEPTH);
	localparam int COUNT_BITS   = $clog2(DEPTH + 1);
	localparam int ENTRY_BITS   = ELEMENT_BITS + KEY_BITS;

	// command codes
	localparam logic [1:0] CMD_INSERT     = 2'd0;
	localparam logic [1:0] CMD_INS_UPDATE = 2'd1;
	localparam logic [1:0] CMD_POP        = 2'd2;
	localparam logic [1:0] CMD_CONTAINS   = 2'd3;

	// status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	// configuration register indexes
	localparam logic [0:0] CFG_ORDER_MAX     = 1'd0;
	localparam logic [0:0] CFG_UPDATE_ENABLE = 1'd1;

	typedef struct packed {
		logic [1:0]              command;
		logic [ELEMENT_BITS-1:0] element;
		logic [KEY_BITS-1:0]     priority_key;
	} pq_in_t;

	typedef struct packed {
		logic [ELEMENT_BITS-1:0] popped_element;
		logic [KEY_BITS-1:0]     popped_key;
		logic                    found;
		logic [1:0]              status;
		logic [COUNT_BITS-1:0]   entry_count;
		logic [ELEMENT_BITS-1:0] head_element;
		logic [KEY_BITS-1:0]     head_key;
		logic                    is_empty;
	} pq_out_t;

	typedef struct packed {
		logic [ELEMENT_BITS-1:0] element;
		logic [KEY_BITS-1:0]     key;
	} entry_t;

	// control from the sequencer to the scan accumulator
	typedef struct packed {
		logic                 clr;
		logic                 valid;
		logic                 match_en;
		logic [ADDR_BITS-1:0] idx;
	} scan_ctl_t;

	// running results of one pass over the store
	typedef struct packed {
		logic                    hit;
		logic [ADDR_BITS-1:0]    hit_idx;
		logic [KEY_BITS-1:0]     hit_key;
		logic                    have_best;
		logic [ADDR_BITS-1:0]    best_idx;
		logic [ELEMENT_BITS-1:0] best_elem;
		logic [KEY_BITS-1:0]     best_key;
	} scan_res_t;

	// strict comparison: a beats b
	function automatic logic key_better(input logic [KEY_BITS-1:0] a,
		input logic [KEY_BITS-1:0] b, input logic order_max);
		return order_max ? (a > b) : (a < b);
	endfunction

endpackage
`default_nettype wire

### hdl/linear_scan_priority_queue_core.sv
// Top level of the linear-scan priority queue: sequencer, store and result.
//
// Usage: drive request and raise start while busy is low; the command is
// transferred at that clock edge and busy rises. Commands are insert,
// insert-or-update, pop and contains. When the command completes, result
// is shown with result_valid high for exactly one cycle, and busy falls
// in that same cycle, so the next command may be started at once.
// Configuration (order_max, update_enable) is written through cfg_we,
// cfg_index and cfg_data while busy is low; it takes effect at once.
// Passes over the store are read through the single RAM read port. With n
// entries stored at the transfer, a command runs a match/best pass over n
// entries, a decide/write step, for a pop a shift pass over the entries
// behind the popped one, and a head pass over what is left. One command is
// in flight at a time.
// The receiver cannot stall; result holds its value until the next command completes.
// Reset clears the entry count and both configuration bits; the RAM is
// not cleared, as only entries below the count are ever read.
`default_nettype none
module linear_scan_priority_queue_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire lspq_pkg::pq_in_t request,
	output lspq_pkg::pq_out_t     result,
	output logic                  result_valid,
	input  wire logic             cfg_we,
	input  wire logic [0:0]       cfg_index,
	input  wire logic [0:0]       cfg_data
);
	import lspq_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_MOD   = 3'd2;
	localparam logic [2:0] ST_SHIFT = 3'd3;
	localparam logic [2:0] ST_HEAD  = 3'd4;

	logic [2:0]            state_q;
	logic [COUNT_BITS-1:0] occ_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  valid_s1;
	logic [ADDR_BITS-1:0]  idx_s1;
	pq_in_t                req_q;
	logic                  order_max_q;
	logic                  update_enable_q;
	logic [ELEMENT_BITS-1:0] popped_elem_q;
	logic [KEY_BITS-1:0]   popped_key_q;
	logic                  found_q;
	logic [1:0]            status_q;
	pq_out_t               result_q;
	logic                  result_valid_q;

	logic                  scanning;
	logic                  rd_en;
	logic [ADDR_BITS-1:0]  raddr;
	logic                  pass_done;
	logic                  we;
	logic [ADDR_BITS-1:0]  waddr;
	entry_t                wdata;
	entry_t                rdata;
	logic [ENTRY_BITS-1:0] rdata_raw;
	logic                  is_ins;
	logic                  full;
	logic                  ins_ok;
	logic                  upd_ok;
	logic                  pop_live;
	scan_ctl_t             scan_ctl;
	scan_res_t             scan_res;

	// read stream over the store
	assign scanning  = (state_q == ST_SCAN) || (state_q == ST_SHIFT) || (state_q == ST_HEAD);
	assign rd_en     = scanning && (cnt_q < occ_q);
	assign raddr     = cnt_q[ADDR_BITS-1:0];
	assign pass_done = (cnt_q == occ_q) && !valid_s1;

	// command decisions, taken once the first pass has finished
	assign full     = (occ_q == COUNT_BITS'(DEPTH));
	assign is_ins   = (req_q.command == CMD_INSERT) ||
	                  ((req_q.command == CMD_INS_UPDATE) && !scan_res.hit);
	assign ins_ok   = (state_q == ST_MOD) && is_ins && !full;
	assign upd_ok   = (state_q == ST_MOD) && (req_q.command == CMD_INS_UPDATE) &&
	                  scan_res.hit && update_enable_q &&
	                  key_better(req_q.priority_key, scan_res.hit_key, order_max_q);
	assign pop_live = (req_q.command == CMD_POP) && (occ_q != '0);

	// write port: append or key update, or shift one entry down after a pop
	always_comb begin
		we    = 1'b0;
		waddr = occ_q[ADDR_BITS-1:0];
		wdata = '{element: req_q.element, key: req_q.priority_key};
		if (state_q == ST_SHIFT) begin
			we    = valid_s1;
			waddr = ADDR_BITS'(idx_s1 - ADDR_BITS'(1));
			wdata = rdata;
		end else if (ins_ok) begin
			we = 1'b1;
		end else if (upd_ok) begin
			we    = 1'b1;
			waddr = scan_res.hit_idx;
		end
	end

	// scan control: clear at the start of each match or head pass
	always_comb begin
		scan_ctl.clr      = ((state_q == ST_IDLE) && start) ||
		                    ((state_q == ST_MOD) && !pop_live) ||
		                    ((state_q == ST_SHIFT) && pass_done);
		scan_ctl.valid    = valid_s1;
		scan_ctl.match_en = (state_q == ST_SCAN);
		scan_ctl.idx      = idx_s1;
	end

	lspq_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (rd_en),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	assign rdata = rdata_raw;

	lspq_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.entry     (rdata),
		.match_elem(req_q.element),
		.order_max (order_max_q),
		.res       (scan_res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_max_q     <= 1'b0;
			update_enable_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ORDER_MAX) begin
				order_max_q <= cfg_data[0];
			end
			if (cfg_index == CFG_UPDATE_ENABLE) begin
				update_enable_q <= cfg_data[0];
			end
		end
	end

	// read pipeline tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= raddr;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			occ_q          <= '0;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						cnt_q <= COUNT_BITS'(cnt_q + COUNT_BITS'(1));
					end else if (pass_done) begin
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (pop_live) begin
						cnt_q   <= COUNT_BITS'(scan_res.best_idx) + COUNT_BITS'(1);
						state_q <= ST_SHIFT;
					end else begin
						cnt_q   <= '0;
						state_q <= ST_HEAD;
					end
					if (ins_ok) begin
						occ_q <= COUNT_BITS'(occ_q + COUNT_BITS'(1));
					end
				end
				ST_SHIFT: begin
					if (rd_en) begin
						cnt_q <= COUNT_BITS'(cnt_q + COUNT_BITS'(1));
					end else if (pass_done) begin
						occ_q   <= COUNT_BITS'(occ_q - COUNT_BITS'(1));
						cnt_q   <= '0;
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					if (rd_en) begin
						cnt_q <= COUNT_BITS'(cnt_q + COUNT_BITS'(1));
					end else if (pass_done) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command payload and per-command outcome
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			req_q         <= request;
			popped_elem_q <= '0;
			popped_key_q  <= '0;
			found_q       <= 1'b0;
			status_q      <= STATUS_OK;
		end else if (state_q == ST_MOD) begin
			if (req_q.command == CMD_POP) begin
				if (occ_q == '0) begin
					status_q <= STATUS_EMPTY;
				end else begin
					popped_elem_q <= scan_res.best_elem;
					popped_key_q  <= scan_res.best_key;
				end
			end else begin
				found_q <= scan_res.hit;
				if (is_ins && full && (req_q.command != CMD_CONTAINS)) begin
					status_q <= STATUS_FULL;
				end
			end
		end
	end

	// capture the result at the end of the head pass
	always_ff @(posedge clk) begin
		if ((state_q == ST_HEAD) && pass_done) begin
			result_q.popped_element <= popped_elem_q;
			result_q.popped_key     <= popped_key_q;
			result_q.found          <= found_q;
			result_q.status         <= status_q;
			result_q.entry_count    <= occ_q;
			if (occ_q == '0) begin
				result_q.head_element <= '0;
				result_q.head_key     <= '0;
				result_q.is_empty     <= 1'b1;
			end else begin
				result_q.head_element <= scan_res.best_elem;
				result_q.head_key     <= scan_res.best_key;
				result_q.is_empty     <= 1'b0;
			end
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule
`default_nettype wire

### hdl/lspq_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module lspq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### hdl/lspq_scan.sv
// Scan accumulator: first element match and best key over one pass.
`default_nettype none
module lspq_scan (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire lspq_pkg::scan_ctl_t               ctl,
	input  wire lspq_pkg::entry_t                  entry,
	input  wire logic [lspq_pkg::ELEMENT_BITS-1:0] match_elem,
	input  wire logic                              order_max,
	output lspq_pkg::scan_res_t                    res
);
	import lspq_pkg::*;

	logic                    hit_q;
	logic [ADDR_BITS-1:0]    hit_idx_q;
	logic [KEY_BITS-1:0]     hit_key_q;
	logic                    have_best_q;
	logic [ADDR_BITS-1:0]    best_idx_q;
	logic [ELEMENT_BITS-1:0] best_elem_q;
	logic [KEY_BITS-1:0]     best_key_q;
	logic                    take_hit;
	logic                    take_best;

	// first match only; strict compare keeps the earliest entry on a tie
	assign take_hit  = ctl.match_en && !hit_q && (entry.element == match_elem);
	assign take_best = !have_best_q || key_better(entry.key, best_key_q, order_max);

	// accumulate over the pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q       <= 1'b0;
			have_best_q <= 1'b0;
		end else if (ctl.clr) begin
			hit_q       <= 1'b0;
			have_best_q <= 1'b0;
		end else if (ctl.valid) begin
			if (take_hit) begin
				hit_q <= 1'b1;
			end
			if (take_best) begin
				have_best_q <= 1'b1;
			end
		end
	end

	// payload of the pass
	always_ff @(posedge clk) begin
		if (ctl.valid && !ctl.clr) begin
			if (take_hit) begin
				hit_idx_q <= ctl.idx;
				hit_key_q <= entry.key;
			end
			if (take_best) begin
				best_idx_q  <= ctl.idx;
				best_elem_q <= entry.element;
				best_key_q  <= entry.key;
			end
		end
	end

	assign res = '{hit: hit_q, hit_idx: hit_idx_q, hit_key: hit_key_q,
	               have_best: have_best_q, best_idx: best_idx_q,
	               best_elem: best_elem_q, best_key: best_key_q};

endmodule
`default_nettype wire
